// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/yfs_pkg.sv =====
// types, constants and helpers for the yuv frame store core
package yfs_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int COL_W  = 9;
  localparam int CFG_W  = 10;
  localparam int DIV_W  = 3;
  localparam int DIVQ_W = 10;
  localparam int SMP_W  = 8;
  localparam int CNT_W  = $clog2(DIVQ_W + 1);

  localparam int MAC_A_W = 18;
  localparam int MAC_B_W = 11;
  localparam int ACC_W   = 32;

  // conversion weights, 16 fraction bits
  localparam logic signed [MAC_A_W-1:0] K_RV = 18'sd92242;
  localparam logic signed [MAC_A_W-1:0] K_GU = 18'sd22643;
  localparam logic signed [MAC_A_W-1:0] K_GV = 18'sd46983;
  localparam logic signed [MAC_A_W-1:0] K_BU = 18'sd116589;
  localparam logic signed [MAC_B_W-1:0] CHROMA_MID = 11'sd128;

  localparam logic [CFG_W-1:0] RESET_WIDTH   = 10'd512;
  localparam logic [CFG_W-1:0] RESET_HEIGHT  = 10'd512;
  localparam logic [DIV_W-1:0] RESET_DIVISOR = 3'd2;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_CHROMA_DIV   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DSEL_ROW = 2'd0,
    DSEL_COL = 2'd1,
    DSEL_WID = 2'd2
  } div_sel_t;

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_LIDX,
    ST_CIDX,
    ST_MEM,
    ST_RED,
    ST_GU,
    ST_GV,
    ST_BLUE,
    ST_BF,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_B_W-1:0] b;
    logic signed [ACC_W-1:0]   c;
  } mac_op_t;

  typedef struct packed {
    logic              done;
    logic [DIVQ_W-1:0] quot;
  } div_res_t;

  // negative gives 0, otherwise integer part saturated to 255
  function automatic logic [SMP_W-1:0] to_byte(input logic signed [ACC_W-1:0] acc);
    logic [SMP_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (|acc[ACC_W-2:24]) begin
      res = '1;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/yfs_ram.sv =====
// generic single-write, single-read ram with registered read data
module yfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/yfs_div.sv =====
// restoring divider by a 3-bit divisor, one quotient bit per cycle
module yfs_div import yfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVQ_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output div_res_t          res
);

  logic [DIVQ_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic              qbit;

  always_comb begin
    trial    = {rem_r, q_r[DIVQ_W-1]};
    qbit     = (trial >= {1'b0, dsr_r});
    q_nxt    = {q_r[DIVQ_W-2:0], qbit};
    rem_nxt  = qbit ? DIV_W'(trial - {1'b0, dsr_r}) : trial[DIV_W-1:0];
    cnt_nxt  = cnt_r - CNT_W'(1);
    done_nxt = (cnt_r == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(DIVQ_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;

endmodule

// ===== rtl/core/yfs_mac.sv =====
// shared multiply-add unit: res = c + a * b, registered
module yfs_mac import yfs_pkg::*; (
  input  logic                    clk,
  input  mac_op_t                 op,
  output logic signed [ACC_W-1:0] res
);

  logic signed [ACC_W-1:0] res_r;
  logic signed [MAC_A_W+MAC_B_W-1:0] prod;

  assign prod = op.a * op.b;

  always_ff @(posedge clk) begin
    res_r <= op.c + ACC_W'(prod);
  end

  assign res = res_r;

endmodule

// ===== rtl/core/yuv_frame_store_rgb_readout_core.sv =====
// yuv frame store with subsampled chroma and rgb readout, top level
// an out of range word goes straight to out_valid in the cycle after it is accepted
// the three chroma quotients go through one bit-serial divider, one after another
// one word in flight: in_ready is high only when idle with no result pending
// reset: synchronous active-low, registers back to 512 x 512 with divisor 2
// plane contents are not cleared and are undefined until written
`include "assert_macros.svh"

module yuv_frame_store_rgb_readout_core import yfs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  input  logic [COL_W-1:0] in_col,
  input  logic [COL_W-1:0] in_row,
  input  logic [SMP_W-1:0] in_luma,
  input  logic [SMP_W-1:0] in_cb,
  input  logic [SMP_W-1:0] in_cr,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SMP_W-1:0] out_red,
  output logic [SMP_W-1:0] out_green,
  output logic [SMP_W-1:0] out_blue,
  output logic             out_out_of_range,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int PLANE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(PLANE_DEPTH);
  localparam int WCLIP       = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
  localparam int HCLIP       = (MAX_HEIGHT > 1023) ? 1023 : MAX_HEIGHT;

  state_t state_r, state_nxt;
  div_sel_t div_sel_r, div_sel_nxt;

  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic [DIV_W-1:0] chroma_divisor_r;

  logic             func_r, oor_r;
  logic [COL_W-1:0] col_r, row_r;
  logic [SMP_W-1:0] luma_r, cb_r, cr_r;
  logic [DIVQ_W-1:0] rowq_r, colq_r, wq_r;
  logic [ADDR_W-1:0] li_r;
  logic [SMP_W-1:0] red_r, green_r, blue_r;

  logic [CFG_W-1:0] w_eff, h_eff;
  logic [DIV_W-1:0] d_eff;
  logic             in_acc, oor_now;

  logic              div_go;
  logic [DIVQ_W-1:0] div_dividend;
  div_res_t          div_res;

  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] mac_res;

  logic              luma_we, ram_re;
  logic [ADDR_W-1:0] ci_addr;
  logic [SMP_W-1:0]  luma_rd;
  logic [2*SMP_W-1:0] chroma_rd;

  logic signed [MAC_B_W-1:0] du, dv;
  logic signed [ACC_W-1:0]   ys;

  // effective geometry
  always_comb begin
    w_eff = (frame_width_r > CFG_W'(WCLIP)) ? CFG_W'(WCLIP) : frame_width_r;
    h_eff = (frame_height_r > CFG_W'(HCLIP)) ? CFG_W'(HCLIP) : frame_height_r;
    d_eff = (chroma_divisor_r == '0) ? DIV_W'(1) : chroma_divisor_r;
    oor_now = ({1'b0, in_col} >= w_eff) || ({1'b0, in_row} >= h_eff);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= RESET_WIDTH;
      frame_height_r   <= RESET_HEIGHT;
      chroma_divisor_r <= RESET_DIVISOR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r    <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r   <= cfg_data;
        CFG_CHROMA_DIV:   chroma_divisor_r <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_sel_r <= DSEL_ROW;
    end else begin
      state_r   <= state_nxt;
      div_sel_r <= div_sel_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    div_sel_nxt  = div_sel_r;
    div_go       = 1'b0;
    luma_we      = 1'b0;
    ram_re       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          div_sel_nxt = DSEL_ROW;
          state_nxt   = oor_now ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_go    = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          if (div_sel_r == DSEL_WID) begin
            state_nxt = ST_LIDX;
          end else begin
            div_sel_nxt = (div_sel_r == DSEL_ROW) ? DSEL_COL : DSEL_WID;
            state_nxt   = ST_DIV_GO;
          end
        end
      end
      ST_LIDX: state_nxt = ST_CIDX;
      ST_CIDX: state_nxt = ST_MEM;
      ST_MEM: begin
        if (func_r == FUNC_WRITE) begin
          luma_we   = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_RED;
        end
      end
      ST_RED:  state_nxt = ST_GU;
      ST_GU:   state_nxt = ST_GV;
      ST_GV:   state_nxt = ST_BLUE;
      ST_BLUE: state_nxt = ST_BF;
      ST_BF:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // divider operand select
  always_comb begin
    unique case (div_sel_r)
      DSEL_ROW: div_dividend = {1'b0, row_r};
      DSEL_COL: div_dividend = {1'b0, col_r};
      DSEL_WID: div_dividend = w_eff;
      default:  div_dividend = '0;
    endcase
  end

  yfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (d_eff),
    .res      (div_res)
  );

  // chroma offsets and scaled luma from the plane read data
  always_comb begin
    du = $signed({3'b0, chroma_rd[2*SMP_W-1:SMP_W]}) - CHROMA_MID;
    dv = $signed({3'b0, chroma_rd[SMP_W-1:0]}) - CHROMA_MID;
    ys = $signed({8'b0, luma_rd, 16'b0});
  end

  // multiply-add operand select
  always_comb begin
    mac_op = '0;
    unique case (state_r)
      ST_LIDX: begin
        mac_op.a = $signed({8'b0, w_eff});
        mac_op.b = $signed({2'b0, row_r});
        mac_op.c = $signed({23'b0, col_r});
      end
      ST_CIDX: begin
        mac_op.a = $signed({8'b0, wq_r});
        mac_op.b = $signed({1'b0, rowq_r});
        mac_op.c = $signed({22'b0, colq_r});
      end
      ST_RED: begin
        mac_op.a = K_RV;
        mac_op.b = dv;
        mac_op.c = ys;
      end
      ST_GU: begin
        mac_op.a = -K_GU;
        mac_op.b = du;
        mac_op.c = ys;
      end
      ST_GV: begin
        mac_op.a = -K_GV;
        mac_op.b = dv;
        mac_op.c = mac_res;
      end
      ST_BLUE: begin
        mac_op.a = K_BU;
        mac_op.b = du;
        mac_op.c = ys;
      end
      default: mac_op = '0;
    endcase
  end

  yfs_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .res (mac_res)
  );

  assign ci_addr = ADDR_W'(mac_res);

  yfs_ram #(
    .WIDTH (SMP_W),
    .DEPTH (PLANE_DEPTH)
  ) u_luma_ram (
    .clk   (clk),
    .we    (luma_we),
    .waddr (li_r),
    .wdata (luma_r),
    .re    (ram_re),
    .raddr (li_r),
    .rdata (luma_rd)
  );

  // cb in the upper byte, cr in the lower
  yfs_ram #(
    .WIDTH (2 * SMP_W),
    .DEPTH (PLANE_DEPTH)
  ) u_chroma_ram (
    .clk   (clk),
    .we    (luma_we),
    .waddr (ci_addr),
    .wdata ({cb_r, cr_r}),
    .re    (ram_re),
    .raddr (ci_addr),
    .rdata (chroma_rd)
  );

  // item capture, quotients, indexes and results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_func;
      col_r   <= in_col;
      row_r   <= in_row;
      luma_r  <= in_luma;
      cb_r    <= in_cb;
      cr_r    <= in_cr;
      oor_r   <= oor_now;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
    end
    if (state_r == ST_DIV_WAIT && div_res.done) begin
      unique case (div_sel_r)
        DSEL_ROW: rowq_r <= div_res.quot;
        DSEL_COL: colq_r <= div_res.quot;
        DSEL_WID: wq_r   <= div_res.quot;
        default: ;
      endcase
    end
    if (state_r == ST_CIDX) begin
      li_r <= ADDR_W'(mac_res);
    end
    if (state_r == ST_GU) begin
      red_r <= to_byte(mac_res);
    end
    if (state_r == ST_BLUE) begin
      green_r <= to_byte(mac_res);
    end
    if (state_r == ST_BF) begin
      blue_r <= to_byte(mac_res);
    end
  end

  assign out_valid        = (state_r == ST_OUT);
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_out_of_range = oor_r;

  `AST_IMPL(a_ready_excl, in_ready, !out_valid, "input ready while a result is pending")
  `AST_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word taken while busy")
  `AST_IMPL(a_oor_black, out_valid && out_out_of_range, (out_red == '0) && (out_green == '0) && (out_blue == '0), "out of range result not black")
  `AST_IMPL(a_no_oor_write, luma_we, !oor_r, "plane write for an out of range position")

endmodule
